### rtl/rof_pkg.sv
// ----------------------------------------------------------------------------
// rof_pkg
// shared types and constants of the rectangle outline framebuffer
// ----------------------------------------------------------------------------
package rof_pkg;

  // field widths
  localparam int OP_W    = 2;
  localparam int IN_XY_W = 10;
  localparam int RECT_W  = 11;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 9;

  // internal widths, sized for the largest supported image (4096 x 4096)
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int LIN_W   = 25;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd2;

  // register byte addresses
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WRITE,
    ST_READ,
    ST_RWAIT,
    ST_ROWS,
    ST_COLS,
    ST_DONE
  } state_t;

  // memory port control from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### rtl/rof_cfg.sv
// ----------------------------------------------------------------------------
// rof_cfg
// apb register file holding the active image width and height
// ----------------------------------------------------------------------------
module rof_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [2:0]                cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready,
  output logic [rof_pkg::CFG_W-1:0] image_width,
  output logic [rof_pkg::CFG_W-1:0] image_height
);

  logic [rof_pkg::CFG_W-1:0] width_r;
  logic [rof_pkg::CFG_W-1:0] height_r;
  logic                      wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register index is paddr / 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rof_pkg::WIDTH_RST;
      height_r <= rof_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == rof_pkg::REG_HEIGHT[2]) begin
        height_r <= cfg_pwdata[rof_pkg::CFG_W-1:0];
      end else begin
        width_r <= cfg_pwdata[rof_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == rof_pkg::REG_HEIGHT[2]) begin
      cfg_prdata = {{(32-rof_pkg::CFG_W){1'b0}}, height_r};
    end else begin
      cfg_prdata = {{(32-rof_pkg::CFG_W){1'b0}}, width_r};
    end
  end

  assign image_width  = width_r;
  assign image_height = height_r;

endmodule

### rtl/rof_pixel_mem.sv
// ----------------------------------------------------------------------------
// rof_pixel_mem
// single-port pixel memory with registered read data
// ----------------------------------------------------------------------------
module rof_pixel_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                      clk,
  input  rof_pkg::mem_ctl_t         mem_ctl,
  input  logic [ADDR_W-1:0]         mem_addr,
  input  logic [rof_pkg::PIX_W-1:0] mem_wdata,
  output logic [rof_pkg::PIX_W-1:0] mem_rdata
);

  logic [rof_pkg::PIX_W-1:0] mem [DEPTH];
  logic [rof_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

### rtl/rof_ctrl.sv
// ----------------------------------------------------------------------------
// rof_ctrl
// operation sequencer: bounds check, pixel access and outline walk
// ----------------------------------------------------------------------------
module rof_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int ADDR_W     = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [55:0]                 in_tdata,
  input  logic [rof_pkg::OP_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,
  input  logic [rof_pkg::CFG_W-1:0]   image_width,
  input  logic [rof_pkg::CFG_W-1:0]   image_height,
  output rof_pkg::mem_ctl_t           mem_ctl,
  output logic [ADDR_W-1:0]           mem_addr,
  output logic [rof_pkg::PIX_W-1:0]   mem_wdata,
  input  logic [rof_pkg::PIX_W-1:0]   mem_rdata
);

  localparam logic [rof_pkg::DIM_W-1:0] MaxW = rof_pkg::DIM_W'(MAX_WIDTH);
  localparam logic [rof_pkg::DIM_W-1:0] MaxH = rof_pkg::DIM_W'(MAX_HEIGHT);

  rof_pkg::state_t state_r, state_nxt;

  logic [rof_pkg::OP_W-1:0]    op_r;
  logic [rof_pkg::IN_XY_W-1:0] x_r;
  logic [rof_pkg::IN_XY_W-1:0] y_r;
  logic [rof_pkg::RECT_W-1:0]  rw_r;
  logic [rof_pkg::RECT_W-1:0]  rh_r;
  logic [rof_pkg::PIX_W-1:0]   pv_r;
  logic [rof_pkg::COORD_W-1:0] x2_r;
  logic [rof_pkg::COORD_W-1:0] y2_r;
  logic [rof_pkg::COORD_W-1:0] pos_r;
  logic                        side_r;
  logic [rof_pkg::PIX_W-1:0]   rd_r;
  logic                        st_r;
  logic                        out_valid_r;
  logic [15:0]                 out_data_r;

  logic                        in_fire;
  logic                        out_free;
  logic [rof_pkg::DIM_W-1:0]   eff_w;
  logic [rof_pkg::DIM_W-1:0]   eff_h;
  logic [rof_pkg::COORD_W-1:0] x_ext;
  logic [rof_pkg::COORD_W-1:0] y_ext;
  logic [rof_pkg::COORD_W-1:0] x2_c;
  logic [rof_pkg::COORD_W-1:0] y2_c;
  logic                        pix_ok;
  logic                        draw_ok;
  logic                        op_ok;
  logic                        row_end;
  logic                        col_end;
  logic [rof_pkg::COORD_W-1:0] cur_x;
  logic [rof_pkg::COORD_W-1:0] cur_y;
  logic [rof_pkg::LIN_W-1:0]   lin_addr;

  assign in_fire  = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;

  // effective image size, clamped to the memory geometry
  always_comb begin
    eff_w = {{(rof_pkg::DIM_W-rof_pkg::CFG_W){1'b0}}, image_width};
    eff_h = {{(rof_pkg::DIM_W-rof_pkg::CFG_W){1'b0}}, image_height};
    if (eff_w > MaxW) begin
      eff_w = MaxW;
    end
    if (eff_h > MaxH) begin
      eff_h = MaxH;
    end
  end

  // bounds checks on the latched operation
  assign x_ext = {{(rof_pkg::COORD_W-rof_pkg::IN_XY_W){1'b0}}, x_r};
  assign y_ext = {{(rof_pkg::COORD_W-rof_pkg::IN_XY_W){1'b0}}, y_r};
  assign x2_c  = x_ext + {{(rof_pkg::COORD_W-rof_pkg::RECT_W){1'b0}}, rw_r}
                 - rof_pkg::COORD_W'(1);
  assign y2_c  = y_ext + {{(rof_pkg::COORD_W-rof_pkg::RECT_W){1'b0}}, rh_r}
                 - rof_pkg::COORD_W'(1);

  assign pix_ok  = ({1'b0, x_ext} < eff_w) && ({1'b0, y_ext} < eff_h);
  assign draw_ok = (rw_r != '0) && (rh_r != '0) &&
                   ({1'b0, x2_c} < eff_w) && ({1'b0, y2_c} < eff_h);

  always_comb begin
    case (op_r)
      rof_pkg::OP_WRITE: op_ok = pix_ok;
      rof_pkg::OP_READ:  op_ok = pix_ok;
      rof_pkg::OP_DRAW:  op_ok = draw_ok;
      default:           op_ok = 1'b0;
    endcase
  end

  assign row_end = side_r && (pos_r == x2_r);
  assign col_end = side_r && ((pos_r + rof_pkg::COORD_W'(1)) == y2_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rof_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = rof_pkg::ST_CHECK;
        end
      end
      rof_pkg::ST_CHECK: begin
        if (!op_ok) begin
          state_nxt = rof_pkg::ST_DONE;
        end else begin
          case (op_r)
            rof_pkg::OP_WRITE: state_nxt = rof_pkg::ST_WRITE;
            rof_pkg::OP_READ:  state_nxt = rof_pkg::ST_READ;
            rof_pkg::OP_DRAW:  state_nxt = rof_pkg::ST_ROWS;
            default:           state_nxt = rof_pkg::ST_DONE;
          endcase
        end
      end
      rof_pkg::ST_WRITE: state_nxt = rof_pkg::ST_DONE;
      rof_pkg::ST_READ:  state_nxt = rof_pkg::ST_RWAIT;
      rof_pkg::ST_RWAIT: state_nxt = rof_pkg::ST_DONE;
      rof_pkg::ST_ROWS: begin
        if (row_end) begin
          if (rh_r > rof_pkg::RECT_W'(2)) begin
            state_nxt = rof_pkg::ST_COLS;
          end else begin
            state_nxt = rof_pkg::ST_DONE;
          end
        end
      end
      rof_pkg::ST_COLS: begin
        if (col_end) begin
          state_nxt = rof_pkg::ST_DONE;
        end
      end
      rof_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rof_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rof_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory port and input handshake
  always_comb begin
    mem_ctl.we = 1'b0;
    mem_ctl.re = 1'b0;
    cur_x      = x_ext;
    cur_y      = y_ext;
    case (state_r)
      rof_pkg::ST_WRITE: begin
        mem_ctl.we = 1'b1;
      end
      rof_pkg::ST_READ: begin
        mem_ctl.re = 1'b1;
      end
      rof_pkg::ST_ROWS: begin
        mem_ctl.we = 1'b1;
        cur_x      = pos_r;
        cur_y      = side_r ? y2_r : y_ext;
      end
      rof_pkg::ST_COLS: begin
        mem_ctl.we = 1'b1;
        cur_x      = side_r ? x2_r : x_ext;
        cur_y      = pos_r;
      end
      default: begin
        mem_ctl.we = 1'b0;
      end
    endcase
  end

  assign in_tready = (state_r == rof_pkg::ST_IDLE);

  // row-major address y * MAX_WIDTH + x
  assign lin_addr =
      {{(rof_pkg::LIN_W-rof_pkg::COORD_W){1'b0}}, cur_y} *
      {{(rof_pkg::LIN_W-rof_pkg::DIM_W){1'b0}}, MaxW} +
      {{(rof_pkg::LIN_W-rof_pkg::COORD_W){1'b0}}, cur_x};
  assign mem_addr  = lin_addr[ADDR_W-1:0];
  assign mem_wdata = pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rof_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operation and walk registers
  always_ff @(posedge clk) begin
    case (state_r)
      rof_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_r <= in_tuser;
          x_r  <= in_tdata[9:0];
          y_r  <= in_tdata[19:10];
          rw_r <= in_tdata[30:20];
          rh_r <= in_tdata[41:31];
          pv_r <= in_tdata[49:42];
          rd_r <= '0;
        end
      end
      rof_pkg::ST_CHECK: begin
        x2_r   <= x2_c;
        y2_r   <= y2_c;
        pos_r  <= x_ext;
        side_r <= 1'b0;
        st_r   <= ~op_ok;
      end
      rof_pkg::ST_RWAIT: begin
        rd_r <= mem_rdata;
      end
      rof_pkg::ST_ROWS: begin
        side_r <= ~side_r;
        if (row_end) begin
          pos_r <= y_ext + rof_pkg::COORD_W'(1);
        end else if (side_r) begin
          pos_r <= pos_r + rof_pkg::COORD_W'(1);
        end
      end
      rof_pkg::ST_COLS: begin
        side_r <= ~side_r;
        if (side_r) begin
          pos_r <= pos_r + rof_pkg::COORD_W'(1);
        end
      end
      default: begin
        side_r <= side_r;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == rof_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rof_pkg::ST_DONE && out_free) begin
      out_data_r <= {7'b0, st_r, rd_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/rectangle_outline_framebuffer.sv
// ----------------------------------------------------------------------------
// rectangle_outline_framebuffer
// 8-bit grayscale framebuffer with pixel write, pixel read and outline draw
// ----------------------------------------------------------------------------
// One operation is taken at a time and each gives one result transaction.
// An operation that fails its checks goes straight to its result; a pixel
// write writes its pixel, a pixel read reads it and registers the data, and
// an outline draw walks its outline through the single memory write port,
// which paints one pixel per cycle (top and bottom rows first, then the
// left and right columns). A new operation is accepted the cycle after its
// predecessor's result lands in the output register, even while that result
// still waits for out_tready. Pixel memory is MAX_WIDTH*MAX_HEIGHT bytes,
// row-major, and is not cleared at reset: a pixel must be written before it
// is read. Image width and height (registers at 0x0 and 0x4, reset 256) are
// clamped to MAX_WIDTH / MAX_HEIGHT and may only change while idle.
// ----------------------------------------------------------------------------
module rectangle_outline_framebuffer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // operation input
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_coord[9:0], y_coord[19:10], rect_width[30:20], rect_height[41:31],
  // pixel_value[49:42], zero fill above
  input  logic [55:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[7:0], status[8], zero fill above
  output logic [15:0] out_tdata,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // memory geometry follows the maximum image size
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  logic [rof_pkg::CFG_W-1:0] image_width;
  logic [rof_pkg::CFG_W-1:0] image_height;
  rof_pkg::mem_ctl_t         mem_ctl;
  logic [AddrW-1:0]          mem_addr;
  logic [rof_pkg::PIX_W-1:0] mem_wdata;
  logic [rof_pkg::PIX_W-1:0] mem_rdata;

  // image size registers
  rof_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // sequencer: checks, address generation, outline walk, result register
  rof_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (AddrW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .image_width  (image_width),
    .image_height (image_height),
    .mem_ctl      (mem_ctl),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .mem_rdata    (mem_rdata)
  );

  // pixel store, one access per cycle
  rof_pixel_mem #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_mem (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

### dv/rectangle_outline_framebuffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rectangle_outline_framebuffer_tb
// pixel write, pixel read and outline draw checked against a local shadow image
// ----------------------------------------------------------------------------
// A directed burst at the reset image size covers the field extremes, every
// operation and every error case. Random traffic then runs through several
// image sizes: zero, one pixel, clamped oversize, and small and full images.
// Each accepted operation updates a shadow copy of the pixel memory and queues
// the expected result transaction, which the monitor compares field by field.
// Reads only ever target pixels that the shadow image has seen written.
// ----------------------------------------------------------------------------
module rectangle_outline_framebuffer_tb;

  localparam int FB_W = 256;
  localparam int FB_H = 256;
  // op code the block does not implement, must come back as an error
  localparam logic [rof_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // operations staged ahead of the driver
  localparam int STAGE_DEPTH = 4;
  // idle cycles waited after the last result
  localparam int SETTLE_CYCLES = 16;
  // long output back-pressure, started once after this many results
  localparam int LONG_HOLD_AT = 100;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [rof_pkg::OP_W-1:0]    op;
    logic [rof_pkg::IN_XY_W-1:0] x;
    logic [rof_pkg::IN_XY_W-1:0] y;
    logic [rof_pkg::RECT_W-1:0]  w;
    logic [rof_pkg::RECT_W-1:0]  h;
    logic [rof_pkg::PIX_W-1:0]   v;
  } pix_op_t;

  typedef struct packed {
    logic [rof_pkg::PIX_W-1:0] rd;
    logic                      st;
  } pix_res_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // operation stream into the block
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // x_coord[9:0], y_coord[19:10], rect_width[30:20], rect_height[41:31],
  // pixel_value[49:42], zero fill above
  logic [55:0] in_tdata = '0;
  // op[1:0]
  logic [1:0]  in_tuser = '0;

  // result stream out of the block
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // read_value[7:0], status[8], zero fill above
  logic [15:0] out_tdata;

  // register port
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the image size registers and the pixel memory
  logic [rof_pkg::CFG_W-1:0] img_w_reg = rof_pkg::WIDTH_RST;
  logic [rof_pkg::CFG_W-1:0] img_h_reg = rof_pkg::HEIGHT_RST;
  logic [rof_pkg::PIX_W-1:0] pix_mem [0:FB_W*FB_H-1];
  bit                        pix_set [0:FB_W*FB_H-1];
  // linear addresses of every pixel written so far, for picking reads
  int unsigned               written_addrs[$];

  pix_op_t  ops_to_send[$];
  pix_res_t pixel_results_due[$];
  int       mismatches = 0;

  rectangle_outline_framebuffer #(
    .MAX_WIDTH  (FB_W),
    .MAX_HEIGHT (FB_H)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(10_000_000);
    $display("rectangle_outline_framebuffer verification failed");
    $finish;
  end

  // size register clamped to the memory size
  function automatic int eff_dim(logic [rof_pkg::CFG_W-1:0] r, int lim);
    return (r > lim) ? lim : int'(r);
  endfunction

  function automatic void plot(int x, int y, logic [rof_pkg::PIX_W-1:0] v);
    int a;
    a = y * FB_W + x;
    pix_mem[a] = v;
    if (!pix_set[a]) begin
      pix_set[a] = 1'b1;
      written_addrs.push_back(a);
    end
  endfunction

  // apply one accepted operation to the shadow image, queue its result
  task automatic predict_pixel_op(input pix_op_t t);
    int ew, eh, px, py, pw, ph, x2, y2, i;
    pix_res_t r;
    ew = eff_dim(img_w_reg, FB_W);
    eh = eff_dim(img_h_reg, FB_H);
    px = t.x;
    py = t.y;
    pw = t.w;
    ph = t.h;
    r.rd = '0;
    r.st = 1'b1;
    case (t.op)
      rof_pkg::OP_WRITE: begin
        if (px < ew && py < eh) begin
          plot(px, py, t.v);
          r.st = 1'b0;
        end
      end
      rof_pkg::OP_READ: begin
        if (px < ew && py < eh) begin
          r.rd = pix_mem[py * FB_W + px];
          r.st = 1'b0;
        end
      end
      rof_pkg::OP_DRAW: begin
        if (pw != 0 && ph != 0 && ew != 0 && eh != 0) begin
          x2 = px + pw - 1;
          y2 = py + ph - 1;
          if (x2 < ew && y2 < eh) begin
            // top and bottom rows, then the columns between them
            for (i = px; i <= x2; i++) begin
              plot(i, py, t.v);
              plot(i, y2, t.v);
            end
            for (i = py + 1; i < y2; i++) begin
              plot(px, i, t.v);
              plot(x2, i, t.v);
            end
            r.st = 1'b0;
          end
        end
      end
      default: ;
    endcase
    pixel_results_due.push_back(r);
  endtask

  // idle length: mostly none or short, a few long, with calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic pix_op_t op_item(logic [rof_pkg::OP_W-1:0] op, int x, int y,
                                      int w, int h, int v);
    pix_op_t t;
    t.op = op;
    t.x = rof_pkg::IN_XY_W'(x);
    t.y = rof_pkg::IN_XY_W'(y);
    t.w = rof_pkg::RECT_W'(w);
    t.h = rof_pkg::RECT_W'(h);
    t.v = rof_pkg::PIX_W'(v);
    return t;
  endfunction

  // random operation for an effective image of ew x eh
  function automatic pix_op_t rand_op(int ew, int eh);
    pix_op_t t;
    int roll, sel, a, tries, wi, hi, xi, yi, wmax, hmax;
    bit found;
    t.x = rof_pkg::IN_XY_W'($urandom_range(0, 1023));
    t.y = rof_pkg::IN_XY_W'($urandom_range(0, 1023));
    t.w = rof_pkg::RECT_W'($urandom_range(0, 1024));
    t.h = rof_pkg::RECT_W'($urandom_range(0, 1024));
    t.v = rof_pkg::PIX_W'($urandom);
    found = 1'b0;
    a = 0;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      t.op = OP_UNUSED;
    end else if (roll < 38) begin
      t.op = rof_pkg::OP_WRITE;
      if (ew > 0 && eh > 0 && $urandom_range(0, 9) != 0) begin
        t.x = rof_pkg::IN_XY_W'($urandom_range(0, ew - 1));
        t.y = rof_pkg::IN_XY_W'($urandom_range(0, eh - 1));
      end
    end else if (roll < 63) begin
      t.op = rof_pkg::OP_READ;
      // in-image reads only hit pixels already written
      if (ew > 0 && eh > 0 && written_addrs.size() > 0 && $urandom_range(0, 4) != 0) begin
        for (tries = 0; tries < 8 && !found; tries++) begin
          a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
          if (a % FB_W < ew && a / FB_W < eh) found = 1'b1;
        end
      end
      if (found) begin
        t.x = rof_pkg::IN_XY_W'(a % FB_W);
        t.y = rof_pkg::IN_XY_W'(a / FB_W);
      end else if ($urandom_range(0, 1)) begin
        t.x = rof_pkg::IN_XY_W'($urandom_range(ew, 1023));
      end else begin
        t.y = rof_pkg::IN_XY_W'($urandom_range(eh, 1023));
      end
    end else begin
      t.op = rof_pkg::OP_DRAW;
      if (ew > 0 && eh > 0) begin
        sel = $urandom_range(0, 19);
        wmax = (ew < 16) ? ew : 16;
        hmax = (eh < 16) ? eh : 16;
        if (sel < 17) begin
          // fits the image, now and then a big one
          wi = $urandom_range(1, wmax);
          hi = $urandom_range(1, hmax);
          if ($urandom_range(0, 39) == 0) wi = $urandom_range(1, ew);
          if ($urandom_range(0, 39) == 0) hi = $urandom_range(1, eh);
          t.w = rof_pkg::RECT_W'(wi);
          t.h = rof_pkg::RECT_W'(hi);
          t.x = rof_pkg::IN_XY_W'($urandom_range(0, ew - wi));
          t.y = rof_pkg::IN_XY_W'($urandom_range(0, eh - hi));
        end else if (sel == 17) begin
          if ($urandom_range(0, 1)) t.w = '0;
          else t.h = '0;
        end else if (sel == 18) begin
          // runs past the right edge
          xi = $urandom_range(0, ew - 1);
          hi = $urandom_range(1, hmax);
          t.x = rof_pkg::IN_XY_W'(xi);
          t.w = rof_pkg::RECT_W'(ew - xi + int'($urandom_range(1, 4)));
          t.h = rof_pkg::RECT_W'(hi);
          t.y = rof_pkg::IN_XY_W'($urandom_range(0, eh - hi));
        end else begin
          // runs past the bottom edge
          yi = $urandom_range(0, eh - 1);
          wi = $urandom_range(1, wmax);
          t.y = rof_pkg::IN_XY_W'(yi);
          t.h = rof_pkg::RECT_W'(eh - yi + int'($urandom_range(1, 4)));
          t.w = rof_pkg::RECT_W'(wi);
          t.x = rof_pkg::IN_XY_W'($urandom_range(0, ew - wi));
        end
      end
    end
    return t;
  endfunction

  // driver: presents staged operations, predicts each accepted one
  pix_op_t on_bus;
  int      send_gap = 0;
  int      send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_pixel_op(on_bus);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          on_bus = ops_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, on_bus.v, on_bus.h, on_bus.w, on_bus.y, on_bus.x};
          in_tuser <= on_bus.op;
          send_gap = idle_len(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure, with one long hold so the input stalls
  int hold_left = 0;
  int rx_calm = 0;
  int results_seen = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_seen++;
      if (!long_hold_done && results_seen == LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left == 0) hold_left = idle_len(rx_calm);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: each result transaction against the oldest expectation
  pix_res_t due;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual read_value %0h status %0b",
                 $time, out_tdata[7:0], out_tdata[8]);
        mismatches++;
      end else begin
        due = pixel_results_due.pop_front();
        if (out_tdata[7:0] !== due.rd) begin
          $display("%0t: read_value mismatch, expected %0h actual %0h",
                   $time, due.rd, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[8] !== due.st) begin
          $display("%0t: status mismatch, expected %0b actual %0b",
                   $time, due.st, out_tdata[8]);
          mismatches++;
        end
      end
    end
  end

  // register write: setup then access, shadow follows the written value
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == rof_pkg::REG_WIDTH) img_w_reg = data[rof_pkg::CFG_W-1:0];
    else if (addr == rof_pkg::REG_HEIGHT) img_h_reg = data[rof_pkg::CFG_W-1:0];
  endtask

  // block is idle once nothing is staged, offered or outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || in_tvalid || pixel_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new image size, then n random operations
  task automatic run_phase(input logic [31:0] wv, input logic [31:0] hv, input int n);
    int ew, eh, k;
    cfg_write(rof_pkg::REG_WIDTH, wv);
    cfg_write(rof_pkg::REG_HEIGHT, hv);
    ew = eff_dim(img_w_reg, FB_W);
    eh = eff_dim(img_h_reg, FB_H);
    for (k = 0; k < n; k++) begin
      do @(negedge clk); while (ops_to_send.size() >= STAGE_DEPTH);
      ops_to_send.push_back(rand_op(ew, eh));
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass at the reset size of 256 x 256
    ops_to_send.push_back(op_item(rof_pkg::OP_WRITE, 0, 0, 0, 0, 8'h00));
    ops_to_send.push_back(op_item(rof_pkg::OP_WRITE, 255, 255, 0, 0, 8'hff));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 0, 0, 0, 0, 0));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 255, 255, 0, 0, 0));
    // coordinates outside the image
    ops_to_send.push_back(op_item(rof_pkg::OP_WRITE, 256, 0, 0, 0, 8'h12));
    ops_to_send.push_back(op_item(rof_pkg::OP_WRITE, 0, 1023, 0, 0, 8'h34));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 1023, 1023, 0, 0, 0));
    // outline around the whole image
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 0, 0, 256, 256, 8'haa));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 255, 0, 0, 0, 0));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 0, 128, 0, 0, 0));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 255, 255, 0, 0, 0));
    // zero-sized rectangles
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 3, 3, 0, 5, 8'h77));
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 3, 3, 5, 0, 8'h77));
    // past the right edge, past the bottom edge
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 250, 0, 7, 2, 8'h66));
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 0, 250, 2, 7, 8'h66));
    // degenerate outlines: one pixel, one column, one row, two by two
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 10, 10, 1, 1, 8'h55));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 10, 10, 0, 0, 0));
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 20, 20, 1, 5, 8'h11));
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 30, 30, 5, 1, 8'h22));
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 40, 40, 2, 2, 8'h33));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 20, 24, 0, 0, 0));
    ops_to_send.push_back(op_item(rof_pkg::OP_READ, 41, 41, 0, 0, 0));
    // unused op code with x, y and pixel value at their top values
    ops_to_send.push_back(op_item(OP_UNUSED, 1023, 1023, 1024, 1024, 8'hff));
    ops_to_send.push_back(op_item(rof_pkg::OP_DRAW, 0, 0, 1024, 1024, 8'h01));
    wait_idle();

    // random traffic over a range of image sizes
    run_phase(32'd256, 32'd256, 300);
    run_phase(32'd1, 32'd1, 40);
    // zero width, then zero height: everything errors
    run_phase(32'd0, 32'd256, 25);
    run_phase(32'd200, 32'd0, 25);
    // oversize values clamp to the memory size
    run_phase(32'd511, 32'd300, 150);
    // upper data bits ignored, 40 x 30
    run_phase(32'hffff_fe28, 32'h8000_001e, 250);
    run_phase(32'd13, 32'd256, 120);
    run_phase(32'd256, 32'd7, 120);
    run_phase(32'd2, 32'd2, 50);

    if (mismatches == 0) begin
      $display("rectangle_outline_framebuffer verification clean");
    end else begin
      $display("rectangle_outline_framebuffer verification failed");
    end
    $finish;
  end

endmodule
